>>> src/btpc_pkg.sv
// Shared types and constants for the barometric compensation block.
// Used by the serial multiplier and the top-level sequencer.
package btpc_pkg;

  localparam int MCAND_W  = 48;
  localparam int MPLIER_W = 26;
  localparam int CNT_W    = 5;
  localparam int PROD_W   = 64;

  localparam logic [2:0] REG_SENS_BASE   = 3'd0;
  localparam logic [2:0] REG_OFFSET_BASE = 3'd1;
  localparam logic [2:0] REG_SENS_TCOEF  = 3'd2;
  localparam logic [2:0] REG_OFF_TCOEF   = 3'd3;
  localparam logic [2:0] REG_REF_TEMP    = 3'd4;
  localparam logic [2:0] REG_TEMP_COEF   = 3'd5;

  localparam logic signed [18:0] TEMP_REF_CENTI = 19'sd2000;
  localparam logic signed [18:0] TEMP_LOW_CENTI = -19'sd1500;

  typedef struct packed {
    logic                       start;
    logic signed [MCAND_W-1:0]  mcand;
    logic [MPLIER_W-1:0]        mplier;
    logic [CNT_W-1:0]           nbits;
  } mul_req_t;

endpackage

>>> src/btpc_serial_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Depends on btpc_pkg for the request type and widths.
module btpc_serial_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  btpc_pkg::mul_req_t                req_i,
  output logic                              done_o,
  output logic signed [btpc_pkg::PROD_W-1:0] prod_o
);
  import btpc_pkg::*;

  logic signed [PROD_W-1:0] acc_q, mc_q;
  logic [MPLIER_W-1:0]      mp_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        acc_q  <= '0;
        mc_q   <= PROD_W'(req_i.mcand);
        mp_q   <= req_i.mplier;
        cnt_q  <= req_i.nbits;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (mp_q[0]) acc_q <= acc_q + mc_q;
        mc_q  <= mc_q <<< 1;
        mp_q  <= mp_q >> 1;
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

>>> src/baro_temp_pressure_compensation.sv
// Barometric temperature/pressure compensation with second-order correction.
// Each request runs its products on the one shared bit-serial multiplier,
// which retires one multiplier bit per cycle (16, 24, 20 or 26 bits per
// product); a pressure request runs extra products below 20.00 C and more
// below -15.00 C. Each product has a launch, a multiplier load and an
// update; the last update also loads the output. One request is in flight at
// a time; a result is held until taken, and the next request can be accepted
// at the edge after the result is taken.
module baro_temp_pressure_compensation (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [23:0]        raw_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic signed [18:0] temperature_out_o,
  output logic signed [31:0] pressure_out_o,
  output logic               saturated_o
);
  import btpc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_LAUNCH, ST_WAIT, ST_OUT} state_e;
  typedef enum logic [2:0] {OP_TEMP, OP_OFF, OP_SENS, OP_T2, OP_SQ, OP_SQ2, OP_P} op_e;

  state_e state_q;
  op_e    op_q;

  logic [15:0] c_sens_q, c_off_q, c_tcs_q, c_tco_q, c_tref_q, c_tsens_q;
  logic signed [25:0] dt_q;
  logic signed [18:0] temp_q, tout_q;
  logic signed [MCAND_W-1:0] off_q, sens_q;
  logic [23:0] raw_q;

  mul_req_t req_q;
  logic mul_done;
  logic signed [PROD_W-1:0] prod;

  btpc_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .done_o (mul_done),
    .prod_o (prod)
  );

  logic [25:0] abs_dt;
  logic [19:0] mag_ref, mag_low;
  logic [MCAND_W-1:0] sq, sq5, sq7, sq11;
  logic signed [MCAND_W-1:0] off_new, sens_new;
  logic signed [PROD_W-1:0] pv, p64;
  logic sat;
  logic signed [18:0] temp_new, t2;
  logic below_ref, below_low;

  always_comb begin
    abs_dt    = dt_q[25] ? 26'(-dt_q) : 26'(dt_q);
    mag_ref   = 20'(20'sd2000 - 20'(temp_q));
    mag_low   = 20'(-20'sd1500 - 20'(temp_q));
    below_ref = temp_q < TEMP_REF_CENTI;
    below_low = temp_q < TEMP_LOW_CENTI;
    sq        = prod[MCAND_W-1:0];
    sq5       = (sq << 2) + sq;
    sq7       = (sq << 3) - sq;
    sq11      = (sq << 3) + (sq << 1) + sq;
    off_new   = $signed({16'b0, c_off_q, 16'b0}) + $signed(prod[54:7]);
    sens_new  = $signed({17'b0, c_sens_q, 15'b0}) + $signed(prod[55:8]);
    temp_new  = TEMP_REF_CENTI + $signed(prod[41:23]);
    t2        = $signed(prod[49:31]);
    pv        = (prod >>> 21) - PROD_W'(off_q);
    p64       = pv >>> 15;
    sat       = !((&p64[PROD_W-1:31]) || !(|p64[PROD_W-1:31]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_TEMP;
      req_q       <= '0;
      out_valid_o <= 1'b0;
      c_sens_q    <= '0;
      c_off_q     <= '0;
      c_tcs_q     <= '0;
      c_tco_q     <= '0;
      c_tref_q    <= '0;
      c_tsens_q   <= '0;
      dt_q        <= '0;
      temp_q      <= TEMP_REF_CENTI;
    end else begin
      req_q.start <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SENS_BASE:   c_sens_q  <= cfg_wdata_i;
          REG_OFFSET_BASE: c_off_q   <= cfg_wdata_i;
          REG_SENS_TCOEF:  c_tcs_q   <= cfg_wdata_i;
          REG_OFF_TCOEF:   c_tco_q   <= cfg_wdata_i;
          REG_REF_TEMP:    c_tref_q  <= cfg_wdata_i;
          REG_TEMP_COEF:   c_tsens_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            raw_q <= raw_sample_i;
            if (command_i) begin
              op_q <= OP_OFF;
            end else begin
              op_q <= OP_TEMP;
              dt_q <= $signed({2'b0, raw_sample_i}) - $signed({2'b0, c_tref_q, 8'b0});
            end
            state_q <= ST_LAUNCH;
          end
        end
        ST_LAUNCH: begin
          req_q.start <= 1'b1;
          unique case (op_q)
            OP_TEMP: begin
              req_q.mcand <= MCAND_W'(dt_q); req_q.mplier <= 26'(c_tsens_q);
              req_q.nbits <= CNT_W'(16);
            end
            OP_OFF: begin
              req_q.mcand <= MCAND_W'(dt_q); req_q.mplier <= 26'(c_tco_q);
              req_q.nbits <= CNT_W'(16);
            end
            OP_SENS: begin
              req_q.mcand <= MCAND_W'(dt_q); req_q.mplier <= 26'(c_tcs_q);
              req_q.nbits <= CNT_W'(16);
            end
            OP_T2: begin
              req_q.mcand <= MCAND_W'(abs_dt); req_q.mplier <= abs_dt;
              req_q.nbits <= CNT_W'(26);
            end
            OP_SQ: begin
              req_q.mcand <= MCAND_W'(mag_ref); req_q.mplier <= 26'(mag_ref);
              req_q.nbits <= CNT_W'(20);
            end
            OP_SQ2: begin
              req_q.mcand <= MCAND_W'(mag_low); req_q.mplier <= 26'(mag_low);
              req_q.nbits <= CNT_W'(20);
            end
            OP_P: begin
              req_q.mcand <= sens_q; req_q.mplier <= 26'(raw_q);
              req_q.nbits <= CNT_W'(24);
            end
            default: ;
          endcase
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mul_done) begin
            state_q <= ST_LAUNCH;
            unique case (op_q)
              OP_TEMP: begin
                temp_q            <= temp_new;
                kind_o            <= 1'b0;
                temperature_out_o <= temp_new;
                pressure_out_o    <= '0;
                saturated_o       <= 1'b0;
                out_valid_o       <= 1'b1;
                state_q           <= ST_OUT;
              end
              OP_OFF: begin
                off_q  <= off_new;
                tout_q <= temp_q;
                op_q   <= OP_SENS;
              end
              OP_SENS: begin
                sens_q <= sens_new;
                op_q   <= below_ref ? OP_T2 : OP_P;
              end
              OP_T2: begin
                tout_q <= temp_q - t2;
                op_q   <= OP_SQ;
              end
              OP_SQ: begin
                // second-order terms below the reference temperature
                off_q  <= off_q - $signed(sq5 >> 1);
                sens_q <= sens_q - $signed(sq5 >> 2);
                op_q   <= below_low ? OP_SQ2 : OP_P;
              end
              OP_SQ2: begin
                off_q  <= off_q - $signed(sq7);
                sens_q <= sens_q - $signed(sq11 >> 1);
                op_q   <= OP_P;
              end
              OP_P: begin
                kind_o            <= 1'b1;
                temperature_out_o <= tout_q;
                saturated_o       <= sat;
                if (!sat) pressure_out_o <= p64[31:0];
                else if (p64[PROD_W-1]) pressure_out_o <= 32'sh8000_0000;
                else pressure_out_o <= 32'sh7fff_ffff;
                out_valid_o <= 1'b1;
                state_q     <= ST_OUT;
              end
              default: ;
            endcase
          end
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

>>> test/baro_temp_pressure_compensation_tb.sv
// Self-checking testbench for baro_temp_pressure_compensation.
// Uses an in-bench compensation predictor and btpc_pkg register indexes.
// Runs a directed table first, then random sample sequences over several
// calibration sets and stall mixes.
module baro_temp_pressure_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import btpc_pkg::*;

  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic               kind;
    logic signed [18:0] temp;
    logic signed [31:0] pres;
    logic               sat;
  } comp_res_t;

  typedef enum logic {ROW_CAL, ROW_SAMPLE} row_op_e;

  typedef struct packed {
    row_op_e          op;
    logic             cmd;
    logic [23:0]      raw;
    logic [5:0][15:0] cal;  // index 0 in the low word
    logic             typed;
    comp_res_t        res;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = REG_SENS_BASE;
  logic [15:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               command_i = 1'b0;
  logic [23:0]        raw_sample_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               kind_o;
  logic signed [18:0] temperature_out_o;
  logic signed [31:0] pressure_out_o;
  logic               saturated_o;

  baro_temp_pressure_compensation dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  // predictor state: calibration copy plus stored dT and first-order TEMP
  logic [15:0] cal_q [6];
  longint      dt_q;
  longint      t1_q;

  comp_res_t   pending_q [$];
  int          mismatches = 0;
  int          unexpected = 0;
  int          n_temp = 0, n_pres = 0, n_cold = 0;
  int          idle_pct = 0, stall_pct = 0;

  function automatic comp_res_t compensate(logic cmd, logic [23:0] raw);
    comp_res_t r;
    longint    rw, off, sens, t_out, p, sq, sq2, off2, sens2, t2;
    rw = longint'(raw);
    r = '0;
    if (!cmd) begin
      dt_q = rw - longint'(cal_q[REG_REF_TEMP]) * 256;
      t1_q = 2000 + ((dt_q * longint'(cal_q[REG_TEMP_COEF])) >>> 23);
      r.temp = t1_q[18:0];
      return r;
    end
    off  = longint'(cal_q[REG_OFFSET_BASE]) * 65536
         + ((longint'(cal_q[REG_OFF_TCOEF]) * dt_q) >>> 7);
    sens = longint'(cal_q[REG_SENS_BASE]) * 32768
         + ((longint'(cal_q[REG_SENS_TCOEF]) * dt_q) >>> 8);
    t_out = t1_q;
    if (t1_q < 2000) begin
      t2 = (dt_q * dt_q) >>> 31;
      sq = (t1_q - 2000) * (t1_q - 2000);
      off2 = (5 * sq) >>> 1;
      sens2 = (5 * sq) >>> 2;
      if (t1_q < -1500) begin
        sq2 = (t1_q + 1500) * (t1_q + 1500);
        off2 += 7 * sq2;
        sens2 += (11 * sq2) >>> 1;
      end
      t_out = t1_q - t2;
      off -= off2;
      sens -= sens2;
    end
    p = (((rw * sens) >>> 21) - off) >>> 15;
    r.kind = 1'b1;
    r.sat = 1'b0;
    if (p > 64'sd2147483647) begin
      p = 64'sd2147483647;
      r.sat = 1'b1;
    end else if (p < -64'sd2147483648) begin
      p = -64'sd2147483648;
      r.sat = 1'b1;
    end
    r.temp = t_out[18:0];
    r.pres = p[31:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    comp_res_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{kind_o, temperature_out_o, pressure_out_o, saturated_o};
      if (pending_q.size() == 0) begin
        unexpected++;
        if (unexpected + mismatches <= 10)
          $display("unexpected result kind=%0d temp=%0d pres=%0d sat=%0d",
                   got.kind, got.temp, got.pres, got.sat);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (unexpected + mismatches <= 10) begin
            $write("mismatch: exp kind=%0d temp=%0d pres=%0d sat=%0d,",
                   want.kind, want.temp, want.pres, want.sat);
            $display(" got kind=%0d temp=%0d pres=%0d sat=%0d",
                     got.kind, got.temp, got.pres, got.sat);
          end
        end
      end
    end
  end

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // writes all six calibration words back to back; block must be idle
  task automatic load_cal(logic [5:0][15:0] words);
    in_valid_i <= 1'b0;
    drain();
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 3'(i);
      cfg_wdata_i <= words[i];
      cal_q[i] = words[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // one request; valid stays high afterwards unless the next call idles
  task automatic send(logic cmd, logic [23:0] raw, logic typed, comp_res_t res);
    int        gap;
    comp_res_t pred;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    raw_sample_i <= raw;
    do @(posedge clk_i); while (in_stall_o);
    pred = compensate(cmd, raw);
    if (cmd) begin
      n_pres++;
      if (t1_q < -1500) n_cold++;
    end else begin
      n_temp++;
    end
    pending_q.push_back(typed ? res : pred);
  endtask

  function automatic logic [23:0] rand_raw();
    case ($urandom_range(4))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_word(int style);
    case (style)
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return ($urandom_range(3) == 0) ? 16'($urandom_range(1) * 16'hFFFF)
                                                : 16'($urandom);
    endcase
  endfunction

  localparam logic [5:0][15:0] CAL_ZERO = '0;
  localparam logic [5:0][15:0] CAL_FULL = {6{16'hFFFF}};
  localparam logic [5:0][15:0] CAL_TYP  =
    {16'd28312, 16'd33464, 16'd23282, 16'd23317, 16'd36924, 16'd40127};
  localparam logic [5:0][15:0] CAL_SENS =
    {16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
  localparam comp_res_t RES_NONE   = '0;
  localparam comp_res_t RES_T_BASE = '{1'b0, 19'sd2000, 32'sd0, 1'b0};
  localparam comp_res_t RES_P_BASE = '{1'b1, 19'sd2000, 32'sd0, 1'b0};

  localparam int N_ROWS = 24;
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    // reset state: pressure before any temperature, all-zero calibration
    '{ROW_SAMPLE, 1'b1, 24'hFFFFFF, CAL_ZERO, 1'b1, RES_P_BASE},
    '{ROW_SAMPLE, 1'b0, 24'h000000, CAL_ZERO, 1'b1, RES_T_BASE},
    '{ROW_SAMPLE, 1'b0, 24'hFFFFFF, CAL_ZERO, 1'b1, RES_T_BASE},
    '{ROW_SAMPLE, 1'b1, 24'h000000, CAL_ZERO, 1'b1, RES_P_BASE},
    '{ROW_CAL,    1'b0, 24'h0,      CAL_TYP,  1'b0, RES_NONE},
    '{ROW_SAMPLE, 1'b1, 24'd8077636, CAL_TYP, 1'b0, RES_NONE},
    '{ROW_SAMPLE, 1'b0, 24'd9085466, CAL_TYP, 1'b0, RES_NONE},
    '{ROW_SAMPLE, 1'b1, 24'd8077636, CAL_TYP, 1'b0, RES_NONE},
    '{ROW_SAMPLE, 1'b1, 24'd8077636, CAL_TYP, 1'b0, RES_NONE},
    // cold: below -15.00 C, repeated pressure must see the same state
    '{ROW_SAMPLE, 1'b0, 24'h000000, CAL_TYP,  1'b0, RES_NONE},
    '{ROW_SAMPLE, 1'b1, 24'h000000, CAL_TYP,  1'b0, RES_NONE},
    '{ROW_SAMPLE, 1'b1, 24'hFFFFFF, CAL_TYP,  1'b0, RES_NONE},
    '{ROW_SAMPLE, 1'b1, 24'hFFFFFF, CAL_TYP,  1'b0, RES_NONE},
    '{ROW_SAMPLE, 1'b0, 24'd7800000, CAL_TYP, 1'b0, RES_NONE},
    '{ROW_SAMPLE, 1'b1, 24'hFFFFFF, CAL_TYP,  1'b0, RES_NONE},
    '{ROW_CAL,    1'b0, 24'h0,      CAL_FULL, 1'b0, RES_NONE},
    '{ROW_SAMPLE, 1'b0, 24'hFFFFFF, CAL_FULL, 1'b0, RES_NONE},
    '{ROW_SAMPLE, 1'b1, 24'hFFFFFF, CAL_FULL, 1'b0, RES_NONE},
    '{ROW_SAMPLE, 1'b0, 24'h000000, CAL_FULL, 1'b0, RES_NONE},
    '{ROW_SAMPLE, 1'b1, 24'hFFFFFF, CAL_FULL, 1'b0, RES_NONE},
    '{ROW_SAMPLE, 1'b1, 24'h000000, CAL_FULL, 1'b0, RES_NONE},
    '{ROW_CAL,    1'b0, 24'h0,      CAL_SENS, 1'b0, RES_NONE},
    '{ROW_SAMPLE, 1'b0, 24'hFFFFFF, CAL_SENS, 1'b0, RES_NONE},
    '{ROW_SAMPLE, 1'b1, 24'hFFFFFF, CAL_SENS, 1'b0, RES_NONE}
  };

  initial begin
    logic [5:0][15:0] words;
    int               sent;
    int               burst;
    int               style;
    for (int i = 0; i < 6; i++) cal_q[i] = '0;
    dt_q = 0;
    t1_q = 2000;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_ROWS; i++) begin
      if (DIRECTED[i].op == ROW_CAL)
        load_cal(DIRECTED[i].cal);
      else
        send(DIRECTED[i].cmd, DIRECTED[i].raw, DIRECTED[i].typed, DIRECTED[i].res);
    end

    // four idle and stall mixes, several calibration sets each
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      for (int set = 0; set < 7; set++) begin
        style = (set == 0) ? 0 : (set == 1) ? 1 : 2;
        for (int w = 0; w < 6; w++) words[w] = rand_word(style);
        in_valid_i <= 1'b0;
        load_cal(words);
        for (int k = 0; k < 16; k++) begin
          if ($urandom_range(9) < 8) begin
            // well-formed: temperature followed by a few pressure reads
            send(1'b0, rand_raw(), 1'b0, RES_NONE);
            burst = $urandom_range(1, 4);
            repeat (burst) send(1'b1, rand_raw(), 1'b0, RES_NONE);
            sent += burst + 1;
          end else begin
            send(1'($urandom), rand_raw(), 1'b0, RES_NONE);
            sent++;
          end
          if (k == 8 && set == 3) begin
            in_valid_i <= 1'b0;
            drain();
          end
        end
      end
    end

    in_valid_i <= 1'b0;
    drain();
    $display("Covered %0d temperature and %0d pressure requests (%0d below -15.00 C)",
             n_temp, n_pres, n_cold);
    $display("over 31 calibration sets and four stall mixes, %0d random requests", sent);
    if (mismatches == 0 && unexpected == 0 && pending_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
